FILE: rtl/core/terrain_snow_dusting_cell_core_macros.svh
// Shared assertion macros.
`ifndef TERRAIN_SNOW_DUSTING_CELL_CORE_MACROS_SVH
`define TERRAIN_SNOW_DUSTING_CELL_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsd check failed");

// Next-cycle implication.
`define TSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsd check failed");

`endif

FILE: rtl/core/tsd_pkg.sv
`timescale 1ns / 1ps
package tsd_pkg;

	localparam int TSD_QB          = 16;
	localparam int TSD_COORD_BITS  = 16;

	localparam logic [31:0] HASH_KX    = 32'd1597334677;
	localparam logic [31:0] HASH_KY    = 32'd3812015801;
	localparam logic [31:0] HASH_KS    = 32'd95868953;
	localparam logic [31:0] HASH_KM    = 32'd2246822519;

	localparam logic [2:0] REG_SCALE    = 3'd0;
	localparam logic [2:0] REG_SNOWLINE = 3'd1;
	localparam logic [2:0] REG_FALLOFF  = 3'd2;
	localparam logic [2:0] REG_MAXD     = 3'd3;
	localparam logic [2:0] REG_COVER    = 3'd4;
	localparam logic [2:0] REG_MELT     = 3'd5;
	localparam logic [2:0] REG_WEIGHTS  = 3'd6;
	localparam logic [2:0] REG_MODE     = 3'd7;

	localparam logic [23:0] RST_SCALE    = 24'd256000;
	localparam logic [14:0] RST_SNOWLINE = 15'd800;
	localparam logic [12:0] RST_FALLOFF  = 13'd250;
	localparam logic [14:0] RST_MAXD     = 15'd800;
	localparam logic [16:0] RST_COVER    = 17'd45875;
	localparam logic [16:0] RST_MELT     = 17'd9830;
	localparam logic [47:0] RST_WEIGHTS  = 48'd98300522332569;
	localparam logic [31:0] RST_MODE     = 32'd7331;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// carried through the altitude divider
	typedef struct packed {
		logic               vld;
		logic               tz;
		logic               tf;
		logic signed [15:0] h;
		logic [16:0]        stable;
		logic [16:0]        retain;
		logic [16:0]        noise;
	} fside_t;

	// carried through the height divider
	typedef struct packed {
		logic               vld;
		logic               sat;
		logic [16:0]        amt;
		logic [14:0]        dep;
		logic signed [15:0] h;
	} bside_t;

endpackage

FILE: rtl/core/tsd_div.sv
`timescale 1ns / 1ps
module tsd_div #(
	parameter int DW = 37,
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [DW-1:0]              num,
	input  logic [DW-1:0]              den,
	input  logic [SW-1:0]              side_in,
	output logic [tsd_pkg::TSD_QB-1:0] quo,
	output logic [SW-1:0]              side_out
);
	import tsd_pkg::*;

	localparam int QB = TSD_QB;

	// restoring divide, one quotient bit per stage; num < den << QB
	logic [DW-1:0] rem_s  [QB-1];
	logic [DW-1:0] den_s  [QB-1];
	logic [QB-1:0] quo_s  [QB];
	logic [SW-1:0] side_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_stg
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QB-1:0] quo_in;
		logic [SW-1:0] sd_in;
		logic [DW-1:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign sd_in  = side_in;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign sd_in  = side_s[i-1];
		end

		assign trial = den_in << (QB - 1 - i);
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[i] <= '0;
			end else if (en) begin
				side_s[i] <= sd_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= quo_in | (QB'(ge) << (QB - 1 - i));
			end
		end

		if (i < QB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? rem_in - trial : rem_in;
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign quo      = quo_s[QB-1];
	assign side_out = side_s[QB-1];

endmodule

FILE: rtl/core/terrain_snow_dusting_cell_core.sv
`timescale 1ns / 1ps
// Snow dusting per terrain cell. One cell is accepted per clock while the result side takes
// transfers; every cell yields exactly one result after passing 7 front stages, a 16-stage
// altitude divider, 9 multiply stages, a 16-stage height divider and one output stage. A stall
// on the result side freezes the whole pipeline. The user must write registers through the cfg
// port only while no cell is in flight; the block does not enforce this.
module terrain_snow_dusting_cell_core #(
	parameter int COORD_BITS = tsd_pkg::TSD_COORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_coord[15:0] y_coord[31:16] height_sample[47:32] slope_deg[62:48]
	// concavity[78:63] existing_depth[94:79] zero[95]
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// dust_amount[16:0] dust_depth[31:17] new_height[47:32]
	output logic [47:0] m_tdata
);
	import tsd_pkg::*;

	localparam int XB = (COORD_BITS < 16) ? COORD_BITS : 16;

	// registers
	logic [23:0]        scale_q;
	logic signed [14:0] snow_q;
	logic [12:0]        fall_q;
	logic [14:0]        maxd_q;
	logic [16:0]        cov_q;
	logic [16:0]        melt_q;
	logic [47:0]        wts_q;
	logic [31:0]        mode_q;
	logic signed [40:0] base_q;
	logic [37:0]        dnh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= RST_SCALE;
			snow_q  <= RST_SNOWLINE;
			fall_q  <= RST_FALLOFF;
			maxd_q  <= RST_MAXD;
			cov_q   <= RST_COVER;
			melt_q  <= RST_MELT;
			wts_q   <= RST_WEIGHTS;
			mode_q  <= RST_MODE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SCALE:    scale_q <= cfg_data[23:0];
				REG_SNOWLINE: snow_q  <= cfg_data[14:0];
				REG_FALLOFF:  fall_q  <= cfg_data[12:0];
				REG_MAXD:     maxd_q  <= cfg_data[14:0];
				REG_COVER:    cov_q   <= cfg_data[16:0];
				REG_MELT:     melt_q  <= cfg_data[16:0];
				REG_WEIGHTS:  wts_q   <= cfg_data;
				REG_MODE:     mode_q  <= cfg_data[31:0];
				default:      ;
			endcase
		end
	end

	logic [23:0] scale_e;
	logic [12:0] fall_e;
	logic [16:0] cov_e;
	logic [16:0] melt_e;
	logic [14:0] md_e;
	logic [16:0] sdiff;
	logic [40:0] sdiff_x;

	assign scale_e = (scale_q == '0) ? 24'd1 : scale_q;
	assign fall_e  = (fall_q == '0) ? 13'd1 : fall_q;
	assign cov_e   = (cov_q > ONE_Q16) ? ONE_Q16 : cov_q;
	assign melt_e  = (melt_q > ONE_Q16) ? ONE_Q16 : melt_q;
	assign md_e    = (maxd_q < 15'd100) ? 15'd100 : maxd_q;
	assign sdiff   = {{2{snow_q[14]}}, snow_q} - {4'b0, fall_e};
	assign sdiff_x = {{24{sdiff[16]}}, sdiff} << 23;

	always_ff @(posedge clk) begin
		base_q <= sdiff_x;
		dnh_q  <= 38'(scale_e) * 38'(14'd10000);
	end

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------- front stages ----------------
	logic [15:0] in_x, in_y, in_ex;
	logic signed [15:0] in_h, in_c;
	logic [14:0] in_sl;
	logic [15:0] in_cc;

	assign in_x  = s_tdata[15:0];
	assign in_y  = s_tdata[31:16];
	assign in_h  = s_tdata[47:32];
	assign in_sl = s_tdata[62:48];
	assign in_c  = s_tdata[78:63];
	assign in_ex = s_tdata[94:79];
	assign in_cc = in_c[15] ? 16'd0 : {in_c[14:0], 1'b0};

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [31:0]        hx_s1, hy_s1, hs_s1;
	logic signed [40:0] hp_s1;
	logic [44:0]        sl_s1;
	logic [30:0]        cm_s1;
	logic signed [15:0] h_s1;
	logic [15:0]        ex_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s1 <= 32'(in_x[XB-1:0]) * HASH_KX;
			hy_s1 <= 32'(in_y[XB-1:0]) * HASH_KY;
			hs_s1 <= 32'(mode_q[19:0]) * HASH_KS;
			hp_s1 <= in_h * $signed({1'b0, scale_e});
			sl_s1 <= 45'({in_sl, 7'b0}) * 45'(23'd7669585);
			cm_s1 <= 31'(in_cc) * 31'(15'd22938);
			h_s1  <= in_h;
			ex_s1 <= in_ex;
		end
	end

	logic [31:0]        hsum;
	logic signed [41:0] num;
	logic               nonpos;
	logic [16:0]        vsl;
	logic [16:0]        slm;
	logic [16:0]        rr;

	assign hsum   = hx_s1 + hy_s1 + hs_s1;
	assign num    = 42'(hp_s1) - 42'(base_q);
	assign nonpos = num[41] || (num == '0);
	assign vsl    = sl_s1[44:28];
	assign slm    = vsl[16] ? ONE_Q16 : vsl;
	assign rr     = 17'd42598 + 17'(cm_s1[30:16]);

	logic [31:0]        hsh_s2;
	logic               tz_s2, tf_s2, rf_s2;
	logic [36:0]        nd_s2;
	logic [32:0]        stp_s2, rtp_s2;
	logic signed [15:0] h_s2;
	logic [15:0]        ex_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			hsh_s2 <= hsum ^ (hsum >> 16);
			tz_s2  <= nonpos;
			tf_s2  <= !nonpos && (num[40:0] >= {4'b0, fall_e, 24'b0});
			nd_s2  <= num[36:0];
			stp_s2 <= 33'(wts_q[47:32]) * 33'(slm);
			rtp_s2 <= 33'(wts_q[31:16]) * 33'(ONE_Q16 - rr);
			rf_s2  <= ex_s1 >= 16'(md_e);
			h_s2   <= h_s1;
			ex_s2  <= ex_s1;
		end
	end

	logic [31:0]        hm_s3;
	logic               tz_s3, tf_s3, rf_s3;
	logic [36:0]        nd_s3;
	logic [16:0]        st_s3, rt_s3;
	logic signed [15:0] h_s3;
	logic [15:0]        ex_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			hm_s3 <= hsh_s2 * HASH_KM;
			tz_s3 <= tz_s2;
			tf_s3 <= tf_s2;
			rf_s3 <= rf_s2;
			nd_s3 <= nd_s2;
			st_s3 <= ONE_Q16 - 17'(stp_s2[32:16]);
			rt_s3 <= ONE_Q16 - 17'(rtp_s2[32:16]);
			h_s3  <= h_s2;
			ex_s3 <= ex_s2;
		end
	end

	// n = h24 * 65536 / (2^24 - 1): quotient estimate plus one correction
	logic [31:0] hf;
	logic [15:0] nq0;
	logic [24:0] nr;

	assign hf  = hm_s3 ^ (hm_s3 >> 13);
	assign nq0 = hf[23:8];
	assign nr  = {1'b0, hf[7:0], 16'b0} + 25'(nq0);

	logic [16:0]        n_s4;
	logic               tz_s4, tf_s4, rf_s4;
	logic [36:0]        nd_s4;
	logic [16:0]        st_s4, rt_s4;
	logic signed [15:0] h_s4;
	logic [15:0]        ex_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s4  <= 17'(nq0) + 17'(nr >= 25'h0ffffff);
			tz_s4 <= tz_s3;
			tf_s4 <= tf_s3;
			rf_s4 <= rf_s3;
			nd_s4 <= nd_s3;
			st_s4 <= st_s3;
			rt_s4 <= rt_s3;
			h_s4  <= h_s3;
			ex_s4 <= ex_s3;
		end
	end

	logic [31:0]        gm_s5;
	logic               tz_s5, tf_s5, rf_s5;
	logic [36:0]        nd_s5;
	logic [16:0]        st_s5, rt_s5;
	logic signed [15:0] h_s5;
	logic [15:0]        ex_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			gm_s5 <= 32'(n_s4) * 32'(15'd29491);
			tz_s5 <= tz_s4;
			tf_s5 <= tf_s4;
			rf_s5 <= rf_s4;
			nd_s5 <= nd_s4;
			st_s5 <= st_s4;
			rt_s5 <= rt_s4;
			h_s5  <= h_s4;
			ex_s5 <= ex_s4;
		end
	end

	logic [16:0] grit;
	assign grit = 17'd36045 + 17'(gm_s5[31:16]);

	logic [32:0]        ngp_s6;
	logic               tz_s6, tf_s6, rf_s6;
	logic [36:0]        nd_s6;
	logic [16:0]        st_s6, rt_s6;
	logic signed [15:0] h_s6;
	logic [15:0]        ex_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			ngp_s6 <= 33'(wts_q[15:0]) * 33'(ONE_Q16 - grit);
			tz_s6  <= tz_s5;
			tf_s6  <= tf_s5;
			rf_s6  <= rf_s5;
			nd_s6  <= nd_s5;
			st_s6  <= st_s5;
			rt_s6  <= rt_s5;
			h_s6   <= h_s5;
			ex_s6  <= ex_s5;
		end
	end

	fside_t      fs_s7;
	logic [36:0] nd_s7;
	logic        rf_s7;
	logic [15:0] ex_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			fs_s7.tz     <= tz_s6;
			fs_s7.tf     <= tf_s6;
			fs_s7.h      <= h_s6;
			fs_s7.stable <= st_s6;
			fs_s7.retain <= rt_s6;
			fs_s7.noise  <= ONE_Q16 - 17'(ngp_s6[32:16]);
			nd_s7        <= nd_s6;
			rf_s7        <= rf_s6;
			ex_s7        <= ex_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	fside_t fs_in;
	always_comb begin
		fs_in.vld    = v_s7;
		fs_in.tz     = fs_s7.tz;
		fs_in.tf     = fs_s7.tf;
		fs_in.h      = fs_s7.h;
		fs_in.stable = fs_s7.stable;
		fs_in.retain = fs_s7.retain;
		fs_in.noise  = fs_s7.noise;
	end

	// ---------------- altitude and existing-snow dividers ----------------
	logic [15:0] tq, rq;
	fside_t      fs_d;
	logic        rf_d;

	tsd_div #(.DW(37), .SW($bits(fside_t))) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.num      (nd_s7),
		.den      (37'({fall_e, 8'b0})),
		.side_in  (fs_in),
		.quo      (tq),
		.side_out (fs_d)
	);

	tsd_div #(.DW(32), .SW(1)) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.num      ({ex_s7, 16'b0}),
		.den      (32'(md_e)),
		.side_in  (rf_s7),
		.quo      (rq),
		.side_out (rf_d)
	);

	// ---------------- product chain ----------------
	logic [16:0] tv, ratio;
	assign tv    = fs_d.tz ? 17'd0 : (fs_d.tf ? ONE_Q16 : {1'b0, tq});
	assign ratio = rf_d ? ONE_Q16 : {1'b0, rq};

	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;
	logic signed [15:0] h_s8, h_s9, h_s10, h_s11, h_s12, h_s13, h_s14, h_s15, h_s16;

	logic [33:0] tt_s8;
	logic [17:0] tw_s8;
	logic [30:0] bp_s8;
	logic [16:0] st_s8, rt_s8, no_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			tt_s8 <= 34'(tv) * 34'(tv);
			tw_s8 <= 18'd196608 - 18'({tv, 1'b0});
			bp_s8 <= 31'(ratio) * 31'(14'd9830);
			st_s8 <= fs_d.stable;
			rt_s8 <= fs_d.retain;
			no_s8 <= fs_d.noise;
			h_s8  <= fs_d.h;
		end
	end

	logic [51:0] altp_s9;
	logic [13:0] bst_s9;
	logic [16:0] st_s9, rt_s9, no_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			altp_s9 <= 52'(tt_s8) * 52'(tw_s8);
			bst_s9  <= mode_q[31] ? bp_s8[29:16] : 14'd0;
			st_s9   <= st_s8;
			rt_s9   <= rt_s8;
			no_s9   <= no_s8;
			h_s9    <= h_s8;
		end
	end

	logic [33:0] p1_s10;
	logic [13:0] bst_s10;
	logic [16:0] rt_s10, no_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s10  <= 34'(altp_s9[48:32]) * 34'(st_s9);
			bst_s10 <= bst_s9;
			rt_s10  <= rt_s9;
			no_s10  <= no_s9;
			h_s10   <= h_s9;
		end
	end

	logic [33:0] p2_s11;
	logic [13:0] bst_s11;
	logic [16:0] no_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s11  <= 34'(p1_s10[32:16]) * 34'(rt_s10);
			bst_s11 <= bst_s10;
			no_s11  <= no_s10;
			h_s11   <= h_s10;
		end
	end

	logic [33:0] p3_s12;
	logic [13:0] bst_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			p3_s12  <= 34'(p2_s11[32:16]) * 34'(no_s11);
			bst_s12 <= bst_s11;
			h_s12   <= h_s11;
		end
	end

	logic [33:0] p4_s13;
	logic [13:0] bst_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			p4_s13  <= 34'(p3_s12[32:16]) * 34'(cov_e);
			bst_s13 <= bst_s12;
			h_s13   <= h_s12;
		end
	end

	logic [34:0] am_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			am_s14 <= 35'(18'(p4_s13[32:16]) + 18'(bst_s13)) * 35'(ONE_Q16 - melt_e);
			h_s14  <= h_s13;
		end
	end

	logic [16:0] amt_s15;

	always_ff @(posedge clk) begin
		if (adv) begin
			amt_s15 <= (am_s14[34:16] > 19'(ONE_Q16)) ? ONE_Q16 : am_s14[32:16];
			h_s15   <= h_s14;
		end
	end

	logic [31:0] dp_s16;
	logic [16:0] amt_s16;

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s16  <= 32'(maxd_q) * 32'(amt_s15);
			amt_s16 <= amt_s15;
			h_s16   <= h_s15;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else if (adv) begin
			v_s8  <= fs_d.vld;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	// ---------------- height raise divider ----------------
	logic [14:0] dep16;
	bside_t      bs_in, bs_d;
	logic [15:0] hq;

	assign dep16 = dp_s16[30:16];

	always_comb begin
		bs_in.vld = v_s16;
		bs_in.sat = 38'({dep16, 7'b0}) >= dnh_q;
		bs_in.amt = amt_s16;
		bs_in.dep = dep16;
		bs_in.h   = h_s16;
	end

	tsd_div #(.DW(54), .SW($bits(bside_t))) u_hdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.num      (54'({dep16, 23'b0})),
		.den      (54'(dnh_q)),
		.side_in  (bs_in),
		.quo      (hq),
		.side_out (bs_d)
	);

	// ---------------- output stage ----------------
	logic [17:0]        hsumr;
	logic signed [15:0] nh;

	assign hsumr = {{2{bs_d.h[15]}}, bs_d.h} + {2'b0, hq};

	always_comb begin
		if (!mode_q[30]) begin
			nh = bs_d.h;
		end else if (bs_d.sat || (!hsumr[17] && (hsumr[16] || hsumr[15]))) begin
			nh = 16'sd32767;
		end else begin
			nh = hsumr[15:0];
		end
	end

	logic               v_s17;
	logic [16:0]        amt_s17;
	logic [14:0]        dep_s17;
	logic signed [15:0] nh_s17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
		end else if (adv) begin
			v_s17 <= bs_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			amt_s17 <= bs_d.amt;
			dep_s17 <= bs_d.dep;
			nh_s17  <= nh;
		end
	end

	assign m_tvalid = v_s17;
	assign m_tdata  = {nh_s17, dep_s17, amt_s17};

endmodule

FILE: rtl/core/tsd_chk.sv
`timescale 1ns / 1ps
`include "terrain_snow_dusting_cell_core_macros.svh"
module tsd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	`TSD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`TSD_ASSERT_IMP(a_ready_follows, m_tready, s_tready)
	`TSD_ASSERT_IMP(a_amount_range, m_tvalid, m_tdata[16:0] <= 17'd65536)
	`TSD_ASSERT_IMP(a_zero_depth, m_tvalid && (m_tdata[16:0] == 17'd0), m_tdata[31:17] == 15'd0)

endmodule

bind terrain_snow_dusting_cell_core tsd_chk u_tsd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
